// ===== rtl/lsps_pkg.sv =====
package lsps_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int WINDOW_DEPTH = 10;

   function automatic int sensor_weight(input int idx);
      int pos;
      pos = SENSOR_COUNT - 1 - 2 * idx;
      return pos * pos * pos;
   endfunction

   function automatic int max_error();
      int total;
      total = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (sensor_weight(i) > 0) begin
            total = total + sensor_weight(i);
         end
      end
      return total;
   endfunction

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   localparam int ERR_W   = $clog2(max_error() + 1) + 1;
   localparam int SUM_W   = $clog2(WINDOW_DEPTH * max_error() + 1) + 1;
   localparam int GAIN_W  = 8;
   localparam int SPEED_W = 8;
   localparam int TRIM_W  = 9;
   localparam int DRIVE_W = 8;
   localparam int OPA_W   = max_int(max_int(SUM_W, ERR_W + 1), DRIVE_W + 1);
   localparam int PROD_W  = OPA_W + TRIM_W + 1;
   localparam int ACC_W   = PROD_W + 2;
   localparam int CORR_W  = ACC_W - 3;
   localparam int LVL_W   = CORR_W + 1;

   localparam int DATA_W    = 32;
   localparam int REG_COUNT = 6;
   localparam int ADDR_W    = $clog2(REG_COUNT * 4);
   localparam int IDX_W     = ADDR_W - 2;

   localparam logic [IDX_W-1:0] REG_PROP_GAIN  = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_INTEG_GAIN = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_BASE_SPEED = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_LEFT_TRIM  = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_RIGHT_TRIM = IDX_W'(5);

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [SPEED_W-1:0] base_speed;
      logic [TRIM_W-1:0]  left_trim;
      logic [TRIM_W-1:0]  right_trim;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] newest;
      logic signed [ERR_W-1:0] oldest;
      logic signed [SUM_W-1:0] sum;
   } win_data_type;

   typedef struct packed {
      logic start;
      logic accumulate;
   } mac_ctrl_type;

   function automatic logic signed [ERR_W-1:0] line_error(
      input logic [SENSOR_COUNT-1:0] bits
   );
      logic signed [ERR_W-1:0] total;
      total = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (bits[i]) begin
            total = total + ERR_W'(sensor_weight(i));
         end
      end
      return total;
   endfunction

endpackage

// ===== rtl/line_sensor_pid_steering_core.sv =====
// Channel  Direction  Handshake         Payload
// req      in         req_valid/stall   req_sensor_bits
// rsp      out        rsp_valid/stall   rsp_left_drive, rsp_right_drive
// csr      in/out     APB write/read    prop, integ, deriv gains, base speed, trims
//
// Items are paced by the sequencer that runs five products through the single shared
// multiplier; a new item is accepted only once the sequencer is back in idle.
// The result is registered, and the next item is accepted while it waits.
// A stalled result holds the sequencer in its last step until the register frees.
// Reset clears the error window, its sum and the control state.
module line_sensor_pid_steering_core
   import lsps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SENSOR_COUNT-1:0] req_sensor_bits,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DRIVE_W-1:0]      rsp_left_drive,
   output logic [DRIVE_W-1:0]      rsp_right_drive,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_W-1:0]       csr_paddr,
   input  logic [DATA_W-1:0]       csr_pwdata,
   output logic [DATA_W-1:0]       csr_prdata,
   output logic                    csr_pready
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ERR   = 4'd1;
   localparam logic [3:0] S_MULP  = 4'd2;
   localparam logic [3:0] S_MULI  = 4'd3;
   localparam logic [3:0] S_MULD  = 4'd4;
   localparam logic [3:0] S_CORR  = 4'd5;
   localparam logic [3:0] S_LEFT  = 4'd6;
   localparam logic [3:0] S_RIGHT = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   cfg_type                 cfg;
   win_data_type            win;
   mac_ctrl_type            mac_ctrl;
   logic signed [OPA_W-1:0] opa;
   logic [TRIM_W-1:0]       opb;
   logic signed [ACC_W-1:0] acc;

   logic [3:0]                 state_ff;
   logic [3:0]                 state_in;
   logic [SENSOR_COUNT-1:0]    bits_ff;
   logic [SENSOR_COUNT-1:0]    bits_in;
   logic signed [CORR_W-1:0]   corr_ff;
   logic signed [CORR_W-1:0]   corr_in;
   logic [DRIVE_W-1:0]         left_ff;
   logic [DRIVE_W-1:0]         left_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [DRIVE_W-1:0]         rsp_left_ff;
   logic [DRIVE_W-1:0]         rsp_left_in;
   logic [DRIVE_W-1:0]         rsp_right_ff;
   logic [DRIVE_W-1:0]         rsp_right_in;

   logic signed [ACC_W-1:0]  biased;
   logic signed [LVL_W-1:0]  addend;
   logic signed [LVL_W-1:0]  level;
   logic [DRIVE_W-1:0]       clamped;
   logic [DRIVE_W-1:0]       trimmed;
   logic                     out_free;

   function automatic logic [DRIVE_W-1:0] saturate(input logic signed [ACC_W-1:0] p);
      if (|p[ACC_W-1:DRIVE_W+8]) begin
         return {DRIVE_W{1'b1}};
      end
      return p[DRIVE_W+7:8];
   endfunction

   lsps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsps_window u_window (
      .clock       (clock),
      .reset       (reset),
      .update      (state_ff == S_ERR),
      .sensor_bits (bits_ff),
      .win         (win)
   );

   lsps_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .opa   (opa),
      .opb   (opb),
      .acc   (acc)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // The quotient by eight rounds toward zero, so negative sums get a bias of seven.
   assign biased  = acc + (acc[ACC_W-1] ? ACC_W'(7) : ACC_W'(0));
   assign corr_in = CORR_W'(biased >>> 3);

   assign addend = (state_ff == S_RIGHT) ? LVL_W'(corr_ff) : -LVL_W'(corr_ff);
   assign level  = LVL_W'($signed({1'b0, cfg.base_speed})) + addend;

   always_comb begin
      if (level[LVL_W-1]) begin
         clamped = '0;
      end else if (|level[LVL_W-2:DRIVE_W]) begin
         clamped = {DRIVE_W{1'b1}};
      end else begin
         clamped = level[DRIVE_W-1:0];
      end
   end

   assign trimmed = saturate(acc);

   always_comb begin
      mac_ctrl = '0;
      opa      = '0;
      opb      = '0;
      unique case (state_ff)
         S_MULP: begin
            mac_ctrl.start = 1'b1;
            opa = OPA_W'(win.newest);
            opb = TRIM_W'(cfg.prop_gain);
         end
         S_MULI: begin
            mac_ctrl.accumulate = 1'b1;
            opa = OPA_W'(win.sum);
            opb = TRIM_W'(cfg.integ_gain);
         end
         S_MULD: begin
            mac_ctrl.accumulate = 1'b1;
            opa = OPA_W'((ERR_W+1)'(win.newest) - (ERR_W+1)'(win.oldest));
            opb = TRIM_W'(cfg.deriv_gain);
         end
         S_LEFT: begin
            mac_ctrl.start = 1'b1;
            opa = OPA_W'($signed({1'b0, clamped}));
            opb = cfg.left_trim;
         end
         S_RIGHT: begin
            mac_ctrl.start = 1'b1;
            opa = OPA_W'($signed({1'b0, clamped}));
            opb = cfg.right_trim;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      bits_in      = bits_ff;
      left_in      = left_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               bits_in  = req_sensor_bits;
               state_in = S_ERR;
            end
         end
         S_ERR:   state_in = S_MULP;
         S_MULP:  state_in = S_MULI;
         S_MULI:  state_in = S_MULD;
         S_MULD:  state_in = S_CORR;
         S_CORR:  state_in = S_LEFT;
         S_LEFT:  state_in = S_RIGHT;
         S_RIGHT: begin
            left_in  = trimmed;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_left_in  = left_ff;
               rsp_right_in = trimmed;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff      <= bits_in;
      left_ff      <= left_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      if (state_ff == S_CORR) begin
         corr_ff <= corr_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_ERR))
      else $error("accepted item did not start the sequence");

   a_result_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_OUT))
      else $error("result appeared outside the output step");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid && rsp_stall) |=> (state_ff == S_OUT))
      else $error("sequencer left the output step while the result register was full");

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MULP) |-> ($past(state_ff) == S_ERR && req_stall))
      else $error("multiply sequence entered without a window update");
`endif

endmodule

// ===== rtl/lsps_csr.sv =====
module lsps_csr
   import lsps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [IDX_W-1:0] index;
   logic             write_en;

   assign index      = csr_paddr[ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_PROP_GAIN:  cfg_in.prop_gain  = csr_pwdata[GAIN_W-1:0];
            REG_INTEG_GAIN: cfg_in.integ_gain = csr_pwdata[GAIN_W-1:0];
            REG_DERIV_GAIN: cfg_in.deriv_gain = csr_pwdata[GAIN_W-1:0];
            REG_BASE_SPEED: cfg_in.base_speed = csr_pwdata[SPEED_W-1:0];
            REG_LEFT_TRIM:  cfg_in.left_trim  = csr_pwdata[TRIM_W-1:0];
            REG_RIGHT_TRIM: cfg_in.right_trim = csr_pwdata[TRIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PROP_GAIN:  csr_prdata = DATA_W'(cfg_ff.prop_gain);
         REG_INTEG_GAIN: csr_prdata = DATA_W'(cfg_ff.integ_gain);
         REG_DERIV_GAIN: csr_prdata = DATA_W'(cfg_ff.deriv_gain);
         REG_BASE_SPEED: csr_prdata = DATA_W'(cfg_ff.base_speed);
         REG_LEFT_TRIM:  csr_prdata = DATA_W'(cfg_ff.left_trim);
         REG_RIGHT_TRIM: csr_prdata = DATA_W'(cfg_ff.right_trim);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= GAIN_W'(1);
         cfg_ff.integ_gain <= '0;
         cfg_ff.deriv_gain <= '0;
         cfg_ff.base_speed <= SPEED_W'(155);
         cfg_ff.left_trim  <= TRIM_W'(256);
         cfg_ff.right_trim <= TRIM_W'(274);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/lsps_window.sv =====
module lsps_window
   import lsps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  logic [SENSOR_COUNT-1:0] sensor_bits,
   output win_data_type            win
);

   logic signed [ERR_W-1:0] window_ff [WINDOW_DEPTH];
   logic signed [ERR_W-1:0] window_in [WINDOW_DEPTH];
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [ERR_W-1:0] newest_ff;
   logic signed [ERR_W-1:0] newest_in;

   assign win.newest = newest_ff;
   assign win.oldest = window_ff[0];
   assign win.sum    = sum_ff;

   always_comb begin
      newest_in = line_error(sensor_bits);
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[WINDOW_DEPTH-1] = newest_in;
      sum_in = sum_ff - SUM_W'(window_ff[0]) + SUM_W'(newest_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff    <= '0;
         newest_ff <= '0;
      end else if (update) begin
         window_ff <= window_in;
         sum_ff    <= sum_in;
         newest_ff <= newest_in;
      end
   end

endmodule

// ===== rtl/lsps_mac.sv =====
module lsps_mac
   import lsps_pkg::*;
(
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   input  logic signed [OPA_W-1:0] opa,
   input  logic [TRIM_W-1:0]       opb,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod = opa * $signed({1'b0, opb});
   assign acc  = acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = ACC_W'(prod);
      end else if (ctrl.accumulate) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

// ===== dv/line_sensor_pid_steering_checker.sv =====
`timescale 1ns / 100ps

module line_sensor_pid_steering_checker
   import lsps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [SENSOR_COUNT-1:0] req_sensor_bits,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [DRIVE_W-1:0]      rsp_left_drive,
   input  logic [DRIVE_W-1:0]      rsp_right_drive,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_W-1:0]       csr_paddr,
   input  logic [DATA_W-1:0]       csr_pwdata,
   input  logic [DATA_W-1:0]       csr_prdata,
   input  logic                    csr_pready,
   output int                      fail_count,
   output int                      pending_count,
   output int                      pairs_checked
);

   typedef struct packed {
      logic [DRIVE_W-1:0] left;
      logic [DRIVE_W-1:0] right;
   } drive_pair_type;

   cfg_type        cfg;
   int             err_window [WINDOW_DEPTH];
   int             err_sum;
   drive_pair_type drive_q [$];
   int             mismatches = 0;
   int             checked = 0;

   function automatic int sample_error(input logic [SENSOR_COUNT-1:0] bits);
      int total;
      int pos;
      total = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         pos = SENSOR_COUNT - 1 - 2 * i;
         if (bits[i]) begin
            total += pos * pos * pos;
         end
      end
      return total;
   endfunction

   function automatic logic [DRIVE_W-1:0] trimmed_drive(input longint level, input int trim);
      longint scaled;
      if (level < 0) begin
         level = 0;
      end
      if (level > 255) begin
         level = 255;
      end
      scaled = (level * trim) / 256;
      return (scaled > 255) ? DRIVE_W'(255) : DRIVE_W'(scaled);
   endfunction

   // Shifts the new error into the window and works out the drive pair it yields.
   function automatic drive_pair_type advance_window(input logic [SENSOR_COUNT-1:0] bits);
      int             newest;
      longint         corr;
      drive_pair_type pair;
      newest = sample_error(bits);
      err_sum -= err_window[0];
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
         err_window[i] = err_window[i + 1];
      end
      err_window[WINDOW_DEPTH - 1] = newest;
      err_sum += newest;
      corr = longint'(newest) * longint'(cfg.prop_gain)
           + longint'(err_sum) * longint'(cfg.integ_gain)
           + longint'(newest - err_window[0]) * longint'(cfg.deriv_gain);
      corr = corr / 8;
      pair.left  = trimmed_drive(longint'(cfg.base_speed) - corr, int'(cfg.left_trim));
      pair.right = trimmed_drive(longint'(cfg.base_speed) + corr, int'(cfg.right_trim));
      return pair;
   endfunction

   function automatic bit reg_readback(input logic [IDX_W-1:0] idx,
                                       output logic [DATA_W-1:0] value);
      value = '0;
      case (idx)
         REG_PROP_GAIN:  value = DATA_W'(cfg.prop_gain);
         REG_INTEG_GAIN: value = DATA_W'(cfg.integ_gain);
         REG_DERIV_GAIN: value = DATA_W'(cfg.deriv_gain);
         REG_BASE_SPEED: value = DATA_W'(cfg.base_speed);
         REG_LEFT_TRIM:  value = DATA_W'(cfg.left_trim);
         REG_RIGHT_TRIM: value = DATA_W'(cfg.right_trim);
         default:        return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%s", msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] stored;
      drive_pair_type    want;
      if (reset) begin
         cfg.prop_gain  = GAIN_W'(1);
         cfg.integ_gain = GAIN_W'(0);
         cfg.deriv_gain = GAIN_W'(0);
         cfg.base_speed = SPEED_W'(155);
         cfg.left_trim  = TRIM_W'(256);
         cfg.right_trim = TRIM_W'(274);
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            err_window[i] = 0;
         end
         err_sum = 0;
         drive_q.delete();
      end else begin
         idx = csr_paddr[ADDR_W-1:2];
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (idx)
                  REG_PROP_GAIN:  cfg.prop_gain  = csr_pwdata[GAIN_W-1:0];
                  REG_INTEG_GAIN: cfg.integ_gain = csr_pwdata[GAIN_W-1:0];
                  REG_DERIV_GAIN: cfg.deriv_gain = csr_pwdata[GAIN_W-1:0];
                  REG_BASE_SPEED: cfg.base_speed = csr_pwdata[SPEED_W-1:0];
                  REG_LEFT_TRIM:  cfg.left_trim  = csr_pwdata[TRIM_W-1:0];
                  REG_RIGHT_TRIM: cfg.right_trim = csr_pwdata[TRIM_W-1:0];
                  default:        ;
               endcase
            end else if (reg_readback(idx, stored) && csr_prdata !== stored) begin
               flag_mismatch($sformatf("%0t: register %0d read expected %0d, got %0d",
                                       $time, idx, stored, csr_prdata));
            end
         end
         if (req_valid && !req_stall) begin
            drive_q.push_back(advance_window(req_sensor_bits));
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               flag_mismatch($sformatf("%0t: drive pair expected none, got left %0d right %0d",
                                       $time, rsp_left_drive, rsp_right_drive));
            end else begin
               want = drive_q.pop_front();
               checked++;
               if (rsp_left_drive !== want.left) begin
                  flag_mismatch($sformatf("%0t: left_drive expected %0d, got %0d",
                                          $time, want.left, rsp_left_drive));
               end
               if (rsp_right_drive !== want.right) begin
                  flag_mismatch($sformatf("%0t: right_drive expected %0d, got %0d",
                                          $time, want.right, rsp_right_drive));
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= drive_q.size();
      pairs_checked <= checked;
   end

endmodule

// ===== dv/line_sensor_pid_steering_core_test.sv =====
`timescale 1ns / 100ps

module line_sensor_pid_steering_core_test;
   import lsps_pkg::*;

   localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_UNUSED_HI = IDX_W'(7);
   localparam int SETTLE_CYCLES     = 24;
   localparam int RANDOM_PHASES     = 10;
   localparam int SAMPLES_PER_PHASE = 125;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SENSOR_COUNT-1:0] req_sensor_bits = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DRIVE_W-1:0]      rsp_left_drive;
   logic [DRIVE_W-1:0]      rsp_right_drive;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]       csr_paddr = '0;
   logic [DATA_W-1:0]       csr_pwdata = '0;
   logic [DATA_W-1:0]       csr_prdata;
   logic                    csr_pready;

   int fail_count;
   int pending_count;
   int pairs_checked;
   int samples_sent = 0;
   int settings_used = 0;
   int line_pos = 3;
   bit quiet = 1'b0;

   logic [SENSOR_COUNT-1:0] opening_samples [24] = '{
      8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
      8'h40, 8'h80, 8'h0F, 8'hF0, 8'h18, 8'h55, 8'hAA, 8'h01,
      8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h80, 8'h80, 8'h07
   };

   line_sensor_pid_steering_core dut (.*);

   line_sensor_pid_steering_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 33);
   end

   task automatic csr_access(input bit write, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic read_back_all();
      for (int i = 0; i < (1 << IDX_W); i++) begin
         csr_access(1'b0, IDX_W'(i), '0);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Junk above each register's width checks that the block keeps only the low bits.
   task automatic write_settings(input logic [GAIN_W-1:0] prop, input logic [GAIN_W-1:0] integ,
                                 input logic [GAIN_W-1:0] deriv, input logic [SPEED_W-1:0] base,
                                 input logic [TRIM_W-1:0] left, input logic [TRIM_W-1:0] right);
      csr_access(1'b1, REG_PROP_GAIN, (DATA_W'($urandom()) << GAIN_W) | DATA_W'(prop));
      csr_access(1'b1, REG_INTEG_GAIN, (DATA_W'($urandom()) << GAIN_W) | DATA_W'(integ));
      csr_access(1'b1, REG_DERIV_GAIN, (DATA_W'($urandom()) << GAIN_W) | DATA_W'(deriv));
      csr_access(1'b1, REG_BASE_SPEED, (DATA_W'($urandom()) << SPEED_W) | DATA_W'(base));
      csr_access(1'b1, REG_LEFT_TRIM, (DATA_W'($urandom()) << TRIM_W) | DATA_W'(left));
      csr_access(1'b1, REG_RIGHT_TRIM, (DATA_W'($urandom()) << TRIM_W) | DATA_W'(right));
      csr_access(1'b1, REG_UNUSED_LO, DATA_W'($urandom()));
      csr_access(1'b1, REG_UNUSED_HI, DATA_W'($urandom()));
      read_back_all();
      settings_used++;
   endtask

   task automatic send_sample(input logic [SENSOR_COUNT-1:0] bits);
      if (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid       <= 1'b1;
      req_sensor_bits <= bits;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly a narrow line that drifts across the array, with some raw noise mixed in.
   function automatic logic [SENSOR_COUNT-1:0] next_sample();
      int span;
      if ($urandom_range(99) < 25) begin
         return SENSOR_COUNT'($urandom());
      end
      line_pos = line_pos + $urandom_range(2) - 1;
      if (line_pos < 0) begin
         line_pos = 0;
      end
      if (line_pos > SENSOR_COUNT - 1) begin
         line_pos = SENSOR_COUNT - 1;
      end
      span = $urandom_range(1, 3);
      return SENSOR_COUNT'(((1 << span) - 1) << line_pos);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      if ($urandom_range(99) < 50) begin
         return GAIN_W'($urandom_range(4));
      end
      return GAIN_W'($urandom_range(255));
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;
      read_back_all();
      foreach (opening_samples[i]) begin
         send_sample(opening_samples[i]);
      end
      settle();

      write_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 9'h1FF);
      foreach (opening_samples[i]) begin
         send_sample(opening_samples[i]);
      end
      settle();

      write_settings(8'h00, 8'h00, 8'h00, 8'h00, 9'h000, 9'h000);
      foreach (opening_samples[i]) begin
         send_sample(opening_samples[i]);
      end
      settle();

      write_settings(8'd8, 8'd1, 8'd4, 8'd128, 9'd256, 9'd300);
      quiet = 1'b1;
      repeat (SAMPLES_PER_PHASE) send_sample(next_sample());
      settle();
      quiet = 1'b0;

      repeat (RANDOM_PHASES) begin
         write_settings(pick_gain(), pick_gain(), pick_gain(), SPEED_W'($urandom_range(255)),
                        TRIM_W'($urandom_range(511)), TRIM_W'($urandom_range(511)));
         repeat (SAMPLES_PER_PHASE) send_sample(next_sample());
         settle();
      end

      $display("Sent %0d sensor samples under %0d register settings; %0d drive pairs compared.",
               samples_sent, settings_used, pairs_checked);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d drive pairs still outstanding.", pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
